// ===== hdl/jbse_pkg.sv =====
// ----------------------------------------------------------------------------
// jbse_pkg
// Shared types and constants for the block symbol encoder (run/category
// stage of baseline coefficient coding).
// ----------------------------------------------------------------------------
package jbse_pkg;

  localparam int BLOCK_COEFFS = 64;
  localparam int COEFF_W      = 16;
  localparam int MAG_W        = 15;
  localparam int CAT_W        = 4;
  localparam int SYM_W        = 8;
  localparam int RUN_CHUNK    = 16;
  localparam int RUN_SHIFT    = $clog2(RUN_CHUNK);

  localparam logic [SYM_W-1:0] SYM_ZRL = 8'hF0;
  localparam logic [SYM_W-1:0] SYM_EOB = 8'h00;

  // classified coefficient
  typedef struct packed {
    logic             is_zero;
    logic [CAT_W-1:0] cat;
    logic [MAG_W-1:0] bits;
  } cls_t;

  // one result item
  typedef struct packed {
    logic             is_dc;
    logic [SYM_W-1:0] symbol;
    logic [CAT_W-1:0] extra_len;
    logic [MAG_W-1:0] extra_bits;
    logic             block_end;
    logic             last;
  } res_t;

endpackage

// ===== hdl/jbse_classify.sv =====
// ----------------------------------------------------------------------------
// jbse_classify
// Saturates a coefficient to +-32767 and derives its category and the
// extra bits (ones' complement form for negative values).
// ----------------------------------------------------------------------------
module jbse_classify (
  input  logic [jbse_pkg::COEFF_W-1:0] coeff,
  output jbse_pkg::cls_t               cls
);
  import jbse_pkg::*;

  function automatic logic [CAT_W-1:0] category(input logic [MAG_W-1:0] m);
    logic [CAT_W-1:0] c;
    c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) c = CAT_W'(i + 1);
    end
    return c;
  endfunction

  logic                neg;
  logic [COEFF_W-1:0]  negated;
  logic [MAG_W-1:0]    mag;
  logic [CAT_W-1:0]    cat;
  logic [MAG_W-1:0]    mask;

  assign neg     = coeff[COEFF_W-1];
  assign negated = COEFF_W'(0) - coeff;

  always_comb begin
    if (!neg) begin
      mag = coeff[MAG_W-1:0];
    end else if (negated[COEFF_W-1]) begin
      // most negative code saturates
      mag = '1;
    end else begin
      mag = negated[MAG_W-1:0];
    end
  end

  assign cat  = category(mag);
  assign mask = MAG_W'((COEFF_W'(1) << cat) - COEFF_W'(1));

  assign cls.is_zero = (mag == '0);
  assign cls.cat     = cat;
  // mag < 2^cat, so mask - mag is mask ^ mag
  assign cls.bits    = neg ? (mag ^ mask) : mag;

endmodule

// ===== hdl/jbse_sym_ctrl.sv =====
// ----------------------------------------------------------------------------
// jbse_sym_ctrl
// Block position and zero-run tracking. Picks the result for the held
// item: pending ZRL symbols first, then DC, AC or EOB symbol.
// ----------------------------------------------------------------------------
module jbse_sym_ctrl #(
  parameter int BLOCK_COEFFS = jbse_pkg::BLOCK_COEFFS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_v,
  input  jbse_pkg::cls_t cls,
  input  logic           slot_free,
  output jbse_pkg::res_t res,
  output logic           res_v,
  output logic           retire
);
  import jbse_pkg::*;

  localparam int POS_W = $clog2(BLOCK_COEFFS);
  localparam int RUN_W = POS_W;
  localparam int ZC_W  = RUN_W - RUN_SHIFT;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_COEFFS - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic [ZC_W-1:0]  zc_r, zc_nxt;

  logic             is_dc, at_end, no_res, zrl_now, push;
  logic [ZC_W-1:0]  zrl_total;

  assign is_dc     = (pos_r == '0);
  assign at_end    = (pos_r >= LAST_POS);
  assign zrl_total = (!is_dc && !cls.is_zero) ? run_r[RUN_W-1:RUN_SHIFT] : '0;
  assign zrl_now   = (zc_r < zrl_total);
  // inner zero: only the run grows
  assign no_res    = !is_dc && cls.is_zero && !at_end;

  assign res_v  = item_v && !no_res;
  assign push   = res_v && slot_free;
  assign retire = item_v && (no_res || (slot_free && !zrl_now));

  always_comb begin
    res = '0;
    priority if (zrl_now) begin
      res.symbol = SYM_ZRL;
    end else if (is_dc) begin
      res.is_dc      = 1'b1;
      res.symbol     = SYM_W'(cls.cat);
      res.extra_len  = cls.cat;
      res.extra_bits = cls.bits;
      res.last       = 1'b1;
    end else if (cls.is_zero) begin
      res.symbol    = SYM_EOB;
      res.block_end = 1'b1;
      res.last      = 1'b1;
    end else begin
      res.symbol     = {run_r[RUN_SHIFT-1:0], cls.cat};
      res.extra_len  = cls.cat;
      res.extra_bits = cls.bits;
      res.block_end  = at_end;
      res.last       = 1'b1;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    run_nxt = run_r;
    zc_nxt  = zc_r;
    if (retire) begin
      zc_nxt = '0;
      if (is_dc) begin
        run_nxt = '0;
        pos_nxt = POS_W'(1);
      end else begin
        if (cls.is_zero && !at_end) run_nxt = run_r + RUN_W'(1);
        else                        run_nxt = '0;
        pos_nxt = at_end ? '0 : pos_r + POS_W'(1);
      end
    end else if (push && zrl_now) begin
      zc_nxt = zc_r + ZC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      run_r <= '0;
      zc_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      run_r <= run_nxt;
      zc_r  <= zc_nxt;
    end
  end

endmodule

// ===== hdl/jbse_out_reg.sv =====
// ----------------------------------------------------------------------------
// jbse_out_reg
// Result register on the output channel; loads whenever it is empty or its
// item is taken in the same cycle.
// ----------------------------------------------------------------------------
module jbse_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_v,
  input  jbse_pkg::res_t push_res,
  output logic           slot_free,
  output logic           out_v,
  input  logic           out_rdy,
  output jbse_pkg::res_t out_res
);
  import jbse_pkg::*;

  logic valid_r;
  res_t res_r;

  assign slot_free = !valid_r || out_rdy;
  assign out_v     = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= push_v;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && push_v) begin
      res_r <= push_res;
    end
  end

endmodule

// ===== hdl/jpeg_block_symbol_encoder_core.sv =====
// ----------------------------------------------------------------------------
// jpeg_block_symbol_encoder_core
// Turns zigzag-ordered quantized coefficients of 8x8 blocks into DC
// category and AC run/category symbols with their extra bits.
// ----------------------------------------------------------------------------
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+-----
//  in      | in_valid, in_ready, in_coeff                  | in
//  out     | out_valid, out_ready, out_is_dc, out_symbol,  | out
//          | out_extra_len, out_extra_bits, out_block_end, |
//          | out_last                                      |
//
//  one item per cycle unless pending ZRL symbols or out_ready stalls hold it;
//  an item with k ZRL symbols (k <= 3) holds the input register until its k+1
//  results have entered the result register, one per cycle unless out_ready stalls
//  inner zero coefficients leave the input register without waiting, no result
//  reset (rst_n low, synchronous) empties both registers and starts a block
//  a stall on out_ready holds the result register and backs up to in_ready
// ----------------------------------------------------------------------------
module jpeg_block_symbol_encoder_core #(
  parameter int BLOCK_COEFFS = jbse_pkg::BLOCK_COEFFS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [jbse_pkg::COEFF_W-1:0]  in_coeff,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_dc,
  output logic [jbse_pkg::SYM_W-1:0]    out_symbol,
  output logic [jbse_pkg::CAT_W-1:0]    out_extra_len,
  output logic [jbse_pkg::MAG_W-1:0]    out_extra_bits,
  output logic                          out_block_end,
  output logic                          out_last
);
  import jbse_pkg::*;

  logic               item_v_r;
  logic [COEFF_W-1:0] coeff_r;
  cls_t               cls;
  res_t               res, out_res;
  logic               res_v, retire, slot_free;

  assign in_ready = !item_v_r || retire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      coeff_r <= in_coeff;
    end
  end

  jbse_classify u_classify (
    .coeff (coeff_r),
    .cls   (cls)
  );

  jbse_sym_ctrl #(
    .BLOCK_COEFFS (BLOCK_COEFFS)
  ) u_sym_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_v    (item_v_r),
    .cls       (cls),
    .slot_free (slot_free),
    .res       (res),
    .res_v     (res_v),
    .retire    (retire)
  );

  jbse_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_v    (res_v),
    .push_res  (res),
    .slot_free (slot_free),
    .out_v     (out_valid),
    .out_rdy   (out_ready),
    .out_res   (out_res)
  );

  assign out_is_dc      = out_res.is_dc;
  assign out_symbol     = out_res.symbol;
  assign out_extra_len  = out_res.extra_len;
  assign out_extra_bits = out_res.extra_bits;
  assign out_block_end  = out_res.block_end;
  assign out_last       = out_res.last;

endmodule

// ===== hdl/jbse_checker.sv =====
// ----------------------------------------------------------------------------
// jbse_checker
// Port-level checks on the symbol encoder, bound to the top level.
// ----------------------------------------------------------------------------
module jbse_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_is_dc,
  input logic [jbse_pkg::SYM_W-1:0]   out_symbol,
  input logic [jbse_pkg::CAT_W-1:0]   out_extra_len,
  input logic [jbse_pkg::MAG_W-1:0]   out_extra_bits,
  input logic                         out_block_end,
  input logic                         out_last
);
  import jbse_pkg::*;

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) &&
      $stable(out_extra_len) && $stable(out_extra_bits) && $stable(out_last))
    else $error("result item changed while stalled");

  // dc and end-of-block symbols always close their item's burst
  a_single_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_is_dc || out_block_end) |-> out_last)
    else $error("dc or block end symbol not last of its item");

  // extra length always equals the category nibble
  a_len_cat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_extra_len == out_symbol[CAT_W-1:0])
    else $error("extra length differs from category");

  // zero-category ac symbols are only zrl (never last) or eob (block end)
  a_zrl_eob: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_dc && out_symbol[CAT_W-1:0] == '0 |->
      out_extra_bits == '0 &&
      ((out_symbol == SYM_ZRL && !out_last && !out_block_end) ||
       (out_symbol == SYM_EOB && out_last && out_block_end)))
    else $error("malformed zrl or eob symbol");

endmodule

bind jpeg_block_symbol_encoder_core jbse_checker u_jbse_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_is_dc      (out_is_dc),
  .out_symbol     (out_symbol),
  .out_extra_len  (out_extra_len),
  .out_extra_bits (out_extra_bits),
  .out_block_end  (out_block_end),
  .out_last       (out_last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block symbol encoder. Zigzag coefficient
// streams (a directed opening, then whole blocks of varied shape) are fed
// through a valid/ready source with random gaps. Every taken item runs
// through a local run/category model that queues the expected symbols. The
// sink stalls at random, holds off once for a long stretch, and checks each
// symbol field by field against the queue.
// ----------------------------------------------------------------------------
module tb_top;
  import jbse_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int CALM_ITEMS  = 64;   // no idling once the backlog is this short
  localparam int HOLD_AFTER  = 150;  // items taken before the long sink hold-off
  localparam int HOLD_CYCLES = 120;
  localparam int RAND_ITEMS  = 400;

  typedef enum int {SHP_SPARSE, SHP_EMPTY, SHP_CORNERS, SHP_DENSE, SHP_NOISE} blk_shape_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [COEFF_W-1:0]   in_coeff  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_is_dc;
  logic [SYM_W-1:0]     out_symbol;
  logic [CAT_W-1:0]     out_extra_len;
  logic [MAG_W-1:0]     out_extra_bits;
  logic                 out_block_end;
  logic                 out_last;

  logic [COEFF_W-1:0]   coeff_q[$];
  res_t                 exp_syms[$];
  res_t                 want;
  logic [5:0]           blk_pos = '0;
  logic [5:0]           run_len = '0;
  logic                 in_acc = 1'b0;
  int                   n_acc = 0;
  int                   mismatches = 0;
  int                   cycle_cnt = 0;
  int                   gap_cnt = 0;
  int                   stall_cnt = 0;
  int                   hold_cnt = 0;
  logic                 hold_done = 1'b0;

  jpeg_block_symbol_encoder_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_coeff      (in_coeff),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_is_dc     (out_is_dc),
    .out_symbol    (out_symbol),
    .out_extra_len (out_extra_len),
    .out_extra_bits(out_extra_bits),
    .out_block_end (out_block_end),
    .out_last      (out_last)
  );

  // symbols caused by one coefficient; advances position and zero run
  function automatic void encode_coeff(input logic [COEFF_W-1:0] c);
    logic               neg;
    logic [COEFF_W-1:0] mag;
    logic [COEFF_W-1:0] mask;
    logic [COEFF_W-1:0] tmp;
    logic [CAT_W-1:0]   cat;
    logic [MAG_W-1:0]   bits;
    logic               at_end;
    res_t               r;
    res_t               syms[$];
    int                 k;
    neg = c[COEFF_W-1];
    mag = neg ? (~c + 1'b1) : c;
    if (mag > 16'd32767) mag = 16'd32767;
    cat = '0;
    for (k = 0; k < MAG_W; k++)
      if (mag[k]) cat = CAT_W'(k + 1);
    mask = (16'd1 << cat) - 16'd1;
    tmp  = neg ? (mask - mag) : mag;
    bits = tmp[MAG_W-1:0] & mask[MAG_W-1:0];

    if (blk_pos == 0) begin
      r = '0;
      r.is_dc = 1'b1;
      r.symbol = {4'b0, cat};
      r.extra_len = cat;
      r.extra_bits = bits;
      syms.push_back(r);
      run_len = '0;
      blk_pos = 6'd1;
    end else begin
      at_end = (blk_pos == BLOCK_COEFFS - 1);
      if (mag == 0) begin
        if (at_end) begin
          r = '0;
          r.symbol = SYM_EOB;
          r.block_end = 1'b1;
          syms.push_back(r);
          run_len = '0;
        end else begin
          run_len = run_len + 1'b1;
        end
      end else begin
        while (run_len >= RUN_CHUNK && syms.size() < 3) begin
          r = '0;
          r.symbol = SYM_ZRL;
          syms.push_back(r);
          run_len = run_len - 6'(RUN_CHUNK);
        end
        r = '0;
        r.symbol = {run_len[3:0], cat};
        r.extra_len = cat;
        r.extra_bits = bits;
        r.block_end = at_end;
        syms.push_back(r);
        run_len = '0;
      end
      blk_pos = at_end ? 6'd0 : blk_pos + 1'b1;
    end

    if (syms.size() > 0) syms[syms.size()-1].last = 1'b1;
    foreach (syms[i]) exp_syms.push_back(syms[i]);
  endfunction

  // nonzero value of random category, now and then the most negative code
  function automatic logic [COEFF_W-1:0] rand_coeff();
    int unsigned        c;
    int unsigned        m;
    logic [COEFF_W-1:0] v;
    if ($urandom_range(0, 31) == 0) return 16'h8000;
    c = $urandom_range(1, 15);
    m = (1 << (c - 1)) | $urandom_range(0, (1 << (c - 1)) - 1);
    v = m[COEFF_W-1:0];
    if ($urandom_range(0, 1)) v = ~v + 1'b1;
    return v;
  endfunction

  task automatic check_field(input string fname, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    blk_shape_t shape;
    int         blk_idx;
    int         p;
    int         sparsity;
    logic [COEFF_W-1:0] v;

    // saturated dc, full scale, +-1, then exactly one zrl before -2
    coeff_q = '{16'h8000, 16'h7FFF, 16'h8001, 16'hFFFF, 16'h0001};
    repeat (RUN_CHUNK) coeff_q.push_back('0);
    coeff_q.push_back(16'hFFFE);

    blk_idx = 0;
    while (coeff_q.size() < RAND_ITEMS + 22) begin
      shape = (blk_idx < 5) ? blk_shape_t'(blk_idx) : blk_shape_t'($urandom_range(0, 4));
      sparsity = $urandom_range(3, 30);
      for (p = coeff_q.size() % BLOCK_COEFFS; p < BLOCK_COEFFS; p++) begin
        case (shape)
          SHP_SPARSE:  v = ($urandom_range(0, sparsity) == 0) ? rand_coeff() : '0;
          SHP_EMPTY:   v = '0;
          // dc and last position only: longest run, three zrl
          SHP_CORNERS: v = (p == 0 || p == BLOCK_COEFFS - 1) ? rand_coeff() : '0;
          SHP_DENSE:   v = ($urandom_range(0, 3) == 0) ? '0 : rand_coeff();
          default:     v = COEFF_W'($urandom_range(0, 16'hFFFF));
        endcase
        coeff_q.push_back(v);
      end
      blk_idx++;
    end

    while (coeff_q.size() != 0 || in_valid || exp_syms.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  // coefficient source
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_valid <= 1'b0;
      end else if (coeff_q.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0) begin
        gap_cnt <= $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (coeff_q.size() != 0) begin
        in_coeff <= coeff_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // symbol sink
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && n_acc >= HOLD_AFTER) begin
      // long hold-off: the block fills and must stall its input
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else if (coeff_q.size() >= CALM_ITEMS && $urandom_range(0, 5) == 0) begin
      stall_cnt <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      in_acc = in_valid && in_ready;
      if (in_acc) begin
        encode_coeff(in_coeff);
        n_acc++;
      end
      if (out_valid && out_ready) begin
        if (exp_syms.size() == 0) begin
          mismatches++;
          $display("%0t: symbol with nothing expected, expected none, actual %02h",
                   $time, out_symbol);
        end else begin
          want = exp_syms.pop_front();
          check_field("is_dc", want.is_dc, out_is_dc);
          check_field("symbol", want.symbol, out_symbol);
          check_field("extra_len", want.extra_len, out_extra_len);
          check_field("extra_bits", want.extra_bits, out_extra_bits);
          check_field("block_end", want.block_end, out_block_end);
          check_field("last", want.last, out_last);
        end
      end
    end
  end

endmodule
